[design/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

	// Default size of the block space, in blocks.
	localparam int unsigned MAX_BLOCKS_DEF = 65536;

	// Item codes.
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;
	localparam logic [1:0] CMD_SET   = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	// Configuration register indexes.
	localparam logic REG_DATA_START   = 1'b0;
	localparam logic REG_TOTAL_BLOCKS = 1'b1;

	// Bitmap byte constants.
	localparam logic [7:0] BYTE_FULL = 8'hFF;
	localparam logic [7:0] BIT_ONE   = 8'h01;

	// Reset value of the total block register.
	localparam logic [16:0] TOTAL_RESET = 17'h10000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] block;
		logic [7:0]  byte_value;
		logic [16:0] free_value;
		logic [16:0] used_value;
	} bba_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] alloc_block;
		logic [16:0] free_now;
		logic [16:0] used_now;
	} bba_rsp_t;

endpackage

[design/bba_bitmap_ram.sv]
`timescale 1ns / 1ps

// Bitmap store: one write port and one read port, read data registered.
module bba_bitmap_ram #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, read data registered.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[design/bitmap_block_allocator_unit.sv]
`timescale 1ns / 1ps
// Set, load and rejected requests are answered from the execute state after acceptance,
// a legal free from the free state after its byte read, an alloc when its scan stops.
// Throughput: one request at a time; the alloc scan reads one bitmap byte per cycle from
// the single RAM read port, so a scan walks at most min(total_blocks, MAX_BLOCKS)/8 bytes.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the bitmap, one byte
// per cycle, and no request is accepted until it completes.
module bitmap_block_allocator_unit #(
	parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [16:0]       cfg_wdata,
	input  logic              req_valid,
	output logic              req_ready,
	input  bba_pkg::bba_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bba_pkg::bba_rsp_t rsp
);

	localparam int unsigned MAP_BYTES = MAX_BLOCKS / 8;
	localparam int unsigned AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_EXEC  = 5'b00100,
		S_SCAN  = 5'b01000,
		S_FREE  = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [AW-1:0]     clr_q;
	bba_pkg::bba_req_t req_q;
	bba_pkg::bba_rsp_t rsp_q, res;
	logic              rsp_valid_q;
	logic [16:0]       free_q, used_q;
	logic [15:0]       hint_q, hint_n;
	logic [15:0]       data_start_q;
	logic [16:0]       total_q;
	logic [13:0]       scan_q, scan_d;

	logic [16:0]       lim;
	logic [13:0]       nbytes;
	logic [15:0]       hint_m1;
	logic [13:0]       start;
	logic [13:0]       scan_nx;
	logic              out_free;
	logic              commit;
	logic [2:0]        zbit;
	logic [7:0]        rd_data;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic              wr_en;
	logic [7:0]        wr_data;

	// Lowest clear bit of a byte that is not full.
	function automatic logic [2:0] low_zero(input logic [7:0] b);
		logic [2:0] k;
		k = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!b[i]) begin
				k = 3'(i);
			end
		end
		return k;
	endfunction

	bba_bitmap_ram #(
		.DEPTH(MAP_BYTES),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Search limit and scan start.
	assign lim = ({15'd0, total_q} > 32'(MAX_BLOCKS)) ? 17'(MAX_BLOCKS) : total_q;
	assign nbytes = lim[16:3];
	assign hint_m1 = hint_q - 16'd1;
	assign start = (hint_q == 16'd0) ? 14'd0 : {1'b0, hint_m1[15:3]};
	assign scan_nx = scan_q + 14'd1;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign zbit = low_zero(rd_data);

	// Request decode, scan step and read-modify-write of the bitmap.
	always_comb begin
		state_d = state_q;
		scan_d = scan_q;
		rd_addr = AW'(scan_q);
		wr_en = 1'b0;
		wr_addr = AW'(scan_q);
		wr_data = 8'd0;
		commit = 1'b0;
		hint_n = hint_q;
		res.status = bba_pkg::ST_OK;
		res.alloc_block = 16'd0;
		res.free_now = free_q;
		res.used_now = used_q;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				if (clr_q == AW'(MAP_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (req_q.cmd)
					bba_pkg::CMD_ALLOC: begin
						if (free_q == 17'd0 || start >= nbytes) begin
							res.status = bba_pkg::ST_NOSPACE;
							commit = out_free;
						end else begin
							rd_addr = AW'(start);
							scan_d = start;
							state_d = S_SCAN;
						end
					end
					bba_pkg::CMD_FREE: begin
						if (req_q.block < data_start_q || {1'b0, req_q.block} >= lim) begin
							res.status = bba_pkg::ST_ILLEGAL;
							commit = out_free;
						end else begin
							rd_addr = AW'(req_q.block[15:3]);
							state_d = S_FREE;
						end
					end
					bba_pkg::CMD_LOAD: begin
						commit = out_free;
						wr_en = commit && (32'(req_q.block) < MAP_BYTES);
						wr_addr = AW'(req_q.block);
						wr_data = req_q.byte_value;
					end
					default: begin
						res.free_now = req_q.free_value;
						res.used_now = req_q.used_value;
						hint_n = req_q.block;
						commit = out_free;
					end
				endcase
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (rd_data != bba_pkg::BYTE_FULL) begin
					// Found a clear bit: claim it, or hold the byte while the output waits.
					commit = out_free;
					res.alloc_block = {scan_q[12:0], zbit};
					res.free_now = free_q - 17'd1;
					res.used_now = used_q + 17'd1;
					hint_n = {scan_q[12:0], zbit};
					wr_en = commit;
					wr_data = rd_data | (bba_pkg::BIT_ONE << zbit);
				end else if (scan_nx >= nbytes) begin
					res.status = bba_pkg::ST_NOSPACE;
					commit = out_free;
				end else begin
					scan_d = scan_nx;
					rd_addr = AW'(scan_nx);
				end
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				rd_addr = AW'(req_q.block[15:3]);
				commit = out_free;
				wr_en = commit;
				wr_addr = AW'(req_q.block[15:3]);
				wr_data = rd_data & ~(bba_pkg::BIT_ONE << req_q.block[2:0]);
				res.free_now = free_q + 17'd1;
				res.used_now = used_q - 17'd1;
				if (hint_q >= req_q.block && req_q.block != 16'd0) begin
					hint_n = req_q.block - 16'd1;
				end
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state, counters and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
			free_q <= 17'd0;
			used_q <= 17'd0;
			hint_q <= 16'd0;
			data_start_q <= 16'd0;
			total_q <= bba_pkg::TOTAL_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
				free_q <= res.free_now;
				used_q <= res.used_now;
				hint_q <= hint_n;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					bba_pkg::REG_DATA_START: data_start_q <= cfg_wdata[15:0];
					bba_pkg::REG_TOTAL_BLOCKS: total_q <= cfg_wdata;
					default: total_q <= total_q;
				endcase
			end
		end
	end

	// Request capture, scan position and output register.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		scan_q <= scan_d;
		if (commit) begin
			rsp_q <= res;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

[design/bba_checker.sv]
`timescale 1ns / 1ps

// Port-level checks on the allocator.
module bba_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input bba_pkg::bba_req_t req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input bba_pkg::bba_rsp_t rsp
);

	// A waiting request holds.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Only one request is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in work");

	// Status is one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == bba_pkg::ST_OK || rsp.status == bba_pkg::ST_NOSPACE
			|| rsp.status == bba_pkg::ST_ILLEGAL)
		else $error("undefined status code");

	// A granted block is reported only with an ok status.
	a_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bba_pkg::ST_OK |-> rsp.alloc_block == 16'd0)
		else $error("block number on a failed request");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

[sim/bitmap_block_allocator_unit_test.sv]
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_test;

	localparam int unsigned MAP_LIMIT = bba_pkg::MAX_BLOCKS_DEF;
	localparam int unsigned MAP_BYTES = bba_pkg::MAX_BLOCKS_DEF / 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = bba_pkg::REG_DATA_START;
	logic [16:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	bba_pkg::bba_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bba_pkg::bba_rsp_t rsp;

	// Mirror of the allocator: bitmap, counters, search hint and registers.
	logic [7:0] map_bytes [MAP_BYTES];
	logic [16:0] free_cnt = '0;
	logic [16:0] used_cnt = '0;
	logic [15:0] hint = '0;
	logic [15:0] cfg_data_start = '0;
	logic [16:0] cfg_total = bba_pkg::TOTAL_RESET;

	bba_pkg::bba_rsp_t replies_due [$];
	bba_pkg::bba_rsp_t latest_reply;
	bba_pkg::bba_rsp_t oldest_reply;
	int unsigned requests_sent = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	bit failed = 1'b0;

	bitmap_block_allocator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Ends a run that hangs.
	initial begin
		#20000000;
		$display("bitmap_block_allocator_unit_test NOT OK");
		$finish;
	end

	// Applies one request to the mirror and returns the reply it must produce.
	function automatic bba_pkg::bba_rsp_t apply_request(bba_pkg::bba_req_t r);
		bba_pkg::bba_rsp_t o;
		int unsigned lim, nbytes, i, k, n;
		bit found;
		o = '0;
		o.status = bba_pkg::ST_OK;
		lim = (cfg_total > MAP_LIMIT) ? MAP_LIMIT : cfg_total;
		case (r.cmd)
			bba_pkg::CMD_ALLOC: begin
				o.status = bba_pkg::ST_NOSPACE;
				if (free_cnt != 0) begin
					nbytes = lim / 8;
					i = (hint == 0) ? 0 : (32'(hint) - 1) >> 3;
					found = 1'b0;
					// Forward scan only; the search never wraps back to byte zero.
					for (; i < nbytes && !found; i++) begin
						if (map_bytes[i] != bba_pkg::BYTE_FULL) begin
							for (k = 0; k < 8 && !found; k++) begin
								if ((map_bytes[i] & (bba_pkg::BIT_ONE << k)) == 0) begin
									n = i * 8 + k;
									map_bytes[i] = map_bytes[i] | (bba_pkg::BIT_ONE << k);
									free_cnt = free_cnt - 1'b1;
									used_cnt = used_cnt + 1'b1;
									hint = n[15:0];
									o.alloc_block = n[15:0];
									o.status = bba_pkg::ST_OK;
									found = 1'b1;
								end
							end
						end
					end
				end
			end
			bba_pkg::CMD_FREE: begin
				if (r.block < cfg_data_start || r.block >= lim) begin
					o.status = bba_pkg::ST_ILLEGAL;
				end else begin
					// A block that is already clear still moves both counters.
					map_bytes[r.block >> 3] = map_bytes[r.block >> 3]
						& ~(bba_pkg::BIT_ONE << r.block[2:0]);
					free_cnt = free_cnt + 1'b1;
					used_cnt = used_cnt - 1'b1;
					if (hint >= r.block && r.block > 0)
						hint = r.block - 16'd1;
				end
			end
			bba_pkg::CMD_LOAD: begin
				if (r.block < MAP_BYTES)
					map_bytes[r.block] = r.byte_value;
			end
			default: begin
				free_cnt = r.free_value;
				used_cnt = r.used_value;
				hint = r.block;
			end
		endcase
		o.free_now = free_cnt;
		o.used_now = used_cnt;
		return o;
	endfunction

	// Presents one request, after a random gap if sender_idles, and records its due reply.
	task automatic issue_request(input logic [1:0] cmd, input logic [15:0] blk,
			input logic [7:0] bval, input logic [16:0] fval, input logic [16:0] uval);
		bba_pkg::bba_req_t item;
		int unsigned gap;
		item.cmd = cmd;
		item.block = blk;
		item.byte_value = bval;
		item.free_value = fval;
		item.used_value = uval;
		gap = sender_idles ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		latest_reply = apply_request(item);
		replies_due.push_back(latest_reply);
		requests_sent++;
	endtask

	// Stops sending and waits for every outstanding reply.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Writes both registers back to back; only called while the block is idle.
	task automatic configure(input logic [15:0] dstart, input logic [16:0] total);
		cfg_wr_en <= 1'b1;
		cfg_index <= bba_pkg::REG_DATA_START;
		cfg_wdata <= {1'b0, dstart};
		@(posedge clk);
		cfg_index <= bba_pkg::REG_TOTAL_BLOCKS;
		cfg_wdata <= total;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_data_start = dstart;
		cfg_total = total;
	endtask

	// Allocation with a zero free count, then the first grant after reset.
	task automatic test_empty_counters();
		issue_request(bba_pkg::CMD_ALLOC, 16'h0, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_SET, 16'h0, 8'h0, 17'h10000, 17'h0);
		issue_request(bba_pkg::CMD_ALLOC, 16'hFFFF, 8'hFF, 17'h1FFFF, 17'h1FFFF);
		wait_drained();
	endtask

	// Free range checks at the register extremes, including a capped total.
	task automatic test_register_extremes();
		configure(16'hFFFF, 17'h1FFFF);
		issue_request(bba_pkg::CMD_FREE, 16'hFFFE, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_FREE, 16'hFFFF, 8'h0, 17'h0, 17'h0);
		wait_drained();
		configure(16'h0, 17'h10000);
		issue_request(bba_pkg::CMD_FREE, 16'h0, 8'h0, 17'h0, 17'h0);
		wait_drained();
		configure(16'd16, 17'd8);
		issue_request(bba_pkg::CMD_FREE, 16'd15, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_FREE, 16'd16, 8'h0, 17'h0, 17'h0);
		wait_drained();
	endtask

	// Partial last byte, start past the limit, no wrap and hint lowering by a free.
	task automatic test_scan_bounds();
		configure(16'h0, 17'd13);
		issue_request(bba_pkg::CMD_LOAD, 16'd0, 8'hFF, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_SET, 16'd0, 8'h0, 17'd4, 17'd0);
		issue_request(bba_pkg::CMD_ALLOC, 16'h0, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_SET, 16'd9, 8'h0, 17'd4, 17'd0);
		issue_request(bba_pkg::CMD_ALLOC, 16'h0, 8'h0, 17'h0, 17'h0);
		wait_drained();
		configure(16'h0, 17'd16);
		issue_request(bba_pkg::CMD_LOAD, 16'd1, 8'h7F, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_ALLOC, 16'h0, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_LOAD, 16'd0, 8'hFE, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_ALLOC, 16'h0, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_FREE, 16'd9, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_ALLOC, 16'h0, 8'h0, 17'h0, 17'h0);
		wait_drained();
	endtask

	// Counter wrap in both directions and loads past the end of the bitmap.
	task automatic test_wrap_and_load();
		configure(16'h0, 17'h10000);
		issue_request(bba_pkg::CMD_SET, 16'h0, 8'h0, 17'h1FFFF, 17'h0);
		issue_request(bba_pkg::CMD_FREE, 16'd100, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_ALLOC, 16'h0, 8'h0, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_LOAD, 16'd8191, 8'hAA, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_LOAD, 16'd8192, 8'h00, 17'h0, 17'h0);
		issue_request(bba_pkg::CMD_SET, 16'd65529, 8'h0, 17'd1, 17'h1FFFF);
		issue_request(bba_pkg::CMD_ALLOC, 16'h0, 8'h0, 17'h0, 17'h0);
		wait_drained();
	endtask

	// Random mounts: each phase picks registers, loads a few bytes, sets the counters
	// and then runs mostly allocations and frees of granted blocks, with some noise.
	task automatic test_random_mounts();
		int unsigned lim, nbytes, op, pick;
		logic [16:0] total, fcnt;
		logic [15:0] dstart, blk;
		logic [15:0] taken [$];
		while (requests_sent < 720) begin
			case ($urandom_range(0, 9))
				0: total = 17'h10000;
				1: total = 17'($urandom_range(17'h10001, 17'h1FFFF));
				2: total = 17'($urandom_range(8, 40));
				default: total = 17'(8 * $urandom_range(1, 64));
			endcase
			lim = (total > MAP_LIMIT) ? MAP_LIMIT : total;
			case ($urandom_range(0, 5))
				0: dstart = 16'h0;
				1: dstart = 16'($urandom);
				default: dstart = 16'($urandom_range(0, lim / 4));
			endcase
			wait_drained();
			configure(dstart, total);
			sender_idles = $urandom_range(0, 3) != 0;
			receiver_idles = $urandom_range(0, 3) != 0;
			taken.delete();
			nbytes = lim / 8;
			repeat ($urandom_range(2, 6))
				issue_request(bba_pkg::CMD_LOAD, 16'($urandom_range(0, nbytes)),
					8'($urandom), 17'($urandom), 17'($urandom));
			fcnt = 17'($urandom_range(1, lim));
			issue_request(bba_pkg::CMD_SET, 16'($urandom_range(0, lim - 1)), 8'($urandom),
				fcnt, 17'(lim) - fcnt);
			repeat (60) begin
				op = $urandom_range(0, 99);
				if (op < 50) begin
					issue_request(bba_pkg::CMD_ALLOC, 16'($urandom), 8'($urandom),
						17'($urandom), 17'($urandom));
					if (latest_reply.status == bba_pkg::ST_OK)
						taken.push_back(latest_reply.alloc_block);
				end else if (op < 78) begin
					if (taken.size() != 0) begin
						pick = $urandom_range(0, taken.size() - 1);
						blk = taken[pick];
						taken.delete(pick);
					end else begin
						blk = 16'($urandom_range(0, lim - 1));
					end
					issue_request(bba_pkg::CMD_FREE, blk, 8'($urandom), 17'($urandom),
						17'($urandom));
				end else if (op < 86) begin
					issue_request(bba_pkg::CMD_FREE, 16'($urandom), 8'($urandom),
						17'($urandom), 17'($urandom));
				end else if (op < 93) begin
					blk = (op < 91) ? 16'($urandom_range(0, nbytes + 1)) : 16'($urandom);
					issue_request(bba_pkg::CMD_LOAD, blk, 8'($urandom), 17'($urandom),
						17'($urandom));
				end else begin
					issue_request(bba_pkg::CMD_SET, 16'($urandom), 8'($urandom),
						17'($urandom), 17'($urandom));
				end
			end
		end
		wait_drained();
	endtask

	// Reply side: a random stall before each reply, skipped in quiet phases.
	initial begin : reply_acceptor
		int unsigned stall;
		forever begin
			stall = receiver_idles ? $urandom_range(0, 10) : 0;
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
		end
	end

	task automatic check_field(input string name, input logic [16:0] want,
			input logic [16:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	// Each accepted reply is matched against the oldest outstanding one.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: reply with none outstanding, got %0h", $time, rsp);
				failed = 1'b1;
			end else begin
				oldest_reply = replies_due.pop_front();
				check_field("status", 17'(oldest_reply.status), 17'(rsp.status));
				check_field("alloc_block", 17'(oldest_reply.alloc_block), 17'(rsp.alloc_block));
				check_field("free_now", oldest_reply.free_now, rsp.free_now);
				check_field("used_now", oldest_reply.used_now, rsp.used_now);
			end
		end
	end

	initial begin
		map_bytes = '{default: '0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_counters();
		test_register_extremes();
		test_scan_bounds();
		test_wrap_and_load();
		test_random_mounts();
		repeat (20) @(posedge clk);
		if (!failed && replies_due.size() == 0) begin
			$display("bitmap_block_allocator_unit_test OK");
		end else begin
			$display("bitmap_block_allocator_unit_test NOT OK");
		end
		$finish;
	end

endmodule

[files.f]
design/bba_pkg.sv
design/bba_bitmap_ram.sv
design/bitmap_block_allocator_unit.sv
design/bba_checker.sv
sim/bitmap_block_allocator_unit_test.sv
